// ===== hdl/dlc_pkg.sv =====
// Shared types and constants for the door lock controller.
// No dependencies; compile first.

package dlc_pkg;

    // Password length and the width of the byte position counter
    localparam int PASSWORD_LEN = 5;
    localparam int IDX_W = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_KEY    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TRIES   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_TICK   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICK   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_TICK  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DONE_TICK   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_TICKS = 3'd6;

    // Register reset values
    localparam logic [7:0] OPEN_KEY_RST    = 8'd43;   // '+'
    localparam logic [2:0] MAX_TRIES_RST   = 3'd3;
    localparam logic [5:0] OPEN_TICK_RST   = 6'd1;
    localparam logic [5:0] HOLD_TICK_RST   = 6'd15;
    localparam logic [5:0] CLOSE_TICK_RST  = 6'd18;
    localparam logic [5:0] DONE_TICK_RST   = 6'd33;
    localparam logic [5:0] ALARM_TICKS_RST = 6'd60;

    // Reply bytes
    localparam logic [7:0] REPLY_PASS = 8'hFF;
    localparam logic [7:0] REPLY_FAIL = 8'h00;

    // Input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Motor drive codes
    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_CW   = 2'd1;
    localparam logic [1:0] MOTOR_ACW  = 2'd2;

    // Reported mode codes
    localparam logic [1:0] MODE_SETUP  = 2'd0;
    localparam logic [1:0] MODE_VERIFY = 2'd1;
    localparam logic [1:0] MODE_DOOR   = 2'd2;
    localparam logic [1:0] MODE_ALARM  = 2'd3;

    typedef enum logic [2:0] {
        PH_SETUP_FIRST,
        PH_SETUP_REPEAT,
        PH_VER_OPTION,
        PH_VER_PASS,
        PH_SYNC_OK,
        PH_SYNC_ALARM,
        PH_DOOR,
        PH_ALARM
    } phase_t;

endpackage

// ===== hdl/dlc_if.sv =====
// Valid/ready channel interfaces for the door lock controller.
// Depends on nothing; compile after dlc_pkg.

interface dlc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface dlc_out_if;
    logic       valid;
    logic       ready;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic [1:0] motor_drive;
    logic       buzzer;
    logic [1:0] mode;

    modport source (output valid, output reply_valid, output reply_byte,
                    output motor_drive, output buzzer, output mode, input ready);
    modport sink   (input valid, input reply_valid, input reply_byte,
                    input motor_drive, input buzzer, input mode, output ready);
endinterface

// ===== hdl/password_door_lock_controller_unit.sv =====
// Door lock controller: password setup/verify, door cycle and alarm lockout.
// Depends on dlc_pkg and the channel interfaces in dlc_if.
//
// Usage
//   keypad : one beat per keypad byte (kind 0) or one-second tick (kind 1).
//   result : exactly one beat per keypad beat, carrying the reply byte (if
//            any), motor drive, buzzer level and mode after that item.
//   cfg_*  : plain register write port, one register per cycle, no read-back;
//            write only while no item is in flight.
// Timing
//   The state update and result are registered at the accept edge and the
//   result beat is offered in the next cycle.
//   Throughput is one item per cycle while results are taken; the single result register sets it.
// Reset
//   Registers return to their defaults, the block enters password setup and
//   no result is pending. Password stores hold no defined value until set.
// Back-pressure
//   A result waiting on a stalled receiver is held; keypad.ready drops until
//   it is taken, and a new beat is accepted in the same cycle it leaves.

module password_door_lock_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    dlc_in_if.sink                             keypad,
    dlc_out_if.source                          result,
    input  logic                               cfg_we,
    input  logic [dlc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dlc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = dlc_pkg::IDX_W;
    localparam int LEN   = dlc_pkg::PASSWORD_LEN;

    // Configuration
    logic [7:0] open_key_reg;
    logic [2:0] max_tries_reg;
    logic [5:0] open_tick_reg;
    logic [5:0] hold_tick_reg;
    logic [5:0] close_tick_reg;
    logic [5:0] done_tick_reg;
    logic [5:0] alarm_ticks_reg;

    // Control state
    dlc_pkg::phase_t phase_reg, phase_next;
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic             mismatch_reg, mismatch_next;
    logic [2:0]       fail_count_reg, fail_count_next;
    logic [7:0]       option_reg, option_next;
    logic [5:0]       tick_count_reg, tick_count_next;
    logic [1:0]       motor_reg, motor_next;

    // Password stores (no reset)
    logic [7:0] first_entry_reg [LEN];
    logic [7:0] stored_pw_reg   [LEN];
    logic       first_we;
    logic       store_copy;

    // Result register
    logic       out_valid_reg;
    logic       reply_valid_reg, reply_valid_next;
    logic [7:0] reply_byte_reg, reply_byte_next;
    logic [1:0] motor_out_reg;
    logic       buzzer_reg, buzzer_next;
    logic [1:0] mode_reg, mode_next;

    logic             accept;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] idx_inc;
    logic             idx_last;
    logic [2:0]       fail_inc;
    logic [5:0]       tick_inc;

    assign keypad.ready = !out_valid_reg || result.ready;
    assign accept       = keypad.valid && keypad.ready;

    assign idx      = ({1'b0, byte_index_reg} < (IDX_W+1)'(LEN)) ? byte_index_reg : '0;
    assign idx_inc  = IDX_W'(idx + 1'b1);
    assign idx_last = (idx == IDX_W'(LEN - 1));
    assign fail_inc = fail_count_reg + 3'd1;
    assign tick_inc = tick_count_reg + 6'd1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_key_reg    <= dlc_pkg::OPEN_KEY_RST;
            max_tries_reg   <= dlc_pkg::MAX_TRIES_RST;
            open_tick_reg   <= dlc_pkg::OPEN_TICK_RST;
            hold_tick_reg   <= dlc_pkg::HOLD_TICK_RST;
            close_tick_reg  <= dlc_pkg::CLOSE_TICK_RST;
            done_tick_reg   <= dlc_pkg::DONE_TICK_RST;
            alarm_ticks_reg <= dlc_pkg::ALARM_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dlc_pkg::REG_OPEN_KEY:    open_key_reg    <= cfg_data;
                dlc_pkg::REG_MAX_TRIES:   max_tries_reg   <= cfg_data[2:0];
                dlc_pkg::REG_OPEN_TICK:   open_tick_reg   <= cfg_data[5:0];
                dlc_pkg::REG_HOLD_TICK:   hold_tick_reg   <= cfg_data[5:0];
                dlc_pkg::REG_CLOSE_TICK:  close_tick_reg  <= cfg_data[5:0];
                dlc_pkg::REG_DONE_TICK:   done_tick_reg   <= cfg_data[5:0];
                dlc_pkg::REG_ALARM_TICKS: alarm_ticks_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        mismatch_next   = mismatch_reg;
        fail_count_next = fail_count_reg;
        option_next     = option_reg;
        tick_count_next = tick_count_reg;
        motor_next      = motor_reg;
        first_we        = 1'b0;
        store_copy      = 1'b0;

        if (keypad.kind == dlc_pkg::KIND_BYTE)
        begin
            case (phase_reg)
                dlc_pkg::PH_SETUP_FIRST:
                begin
                    first_we = 1'b1;
                    if (idx_last)
                    begin
                        byte_index_next = '0;
                        mismatch_next   = 1'b0;
                        phase_next      = dlc_pkg::PH_SETUP_REPEAT;
                    end
                    else
                    begin
                        byte_index_next = idx_inc;
                    end
                end
                dlc_pkg::PH_SETUP_REPEAT:
                begin
                    if (idx_last)
                    begin
                        byte_index_next = '0;
                        mismatch_next   = 1'b0;
                        if (mismatch_reg || first_entry_reg[idx] != keypad.rx_byte)
                        begin
                            phase_next = dlc_pkg::PH_SETUP_FIRST;
                        end
                        else
                        begin
                            store_copy      = 1'b1;
                            fail_count_next = '0;
                            phase_next      = dlc_pkg::PH_VER_OPTION;
                        end
                    end
                    else
                    begin
                        byte_index_next = idx_inc;
                        if (first_entry_reg[idx] != keypad.rx_byte)
                        begin
                            mismatch_next = 1'b1;
                        end
                    end
                end
                dlc_pkg::PH_VER_OPTION:
                begin
                    option_next     = keypad.rx_byte;
                    byte_index_next = '0;
                    mismatch_next   = 1'b0;
                    phase_next      = dlc_pkg::PH_VER_PASS;
                end
                dlc_pkg::PH_VER_PASS:
                begin
                    if (idx_last)
                    begin
                        byte_index_next = '0;
                        mismatch_next   = 1'b0;
                        if (mismatch_reg || stored_pw_reg[idx] != keypad.rx_byte)
                        begin
                            fail_count_next = fail_inc;
                            // a wrapped count of zero also trips the alarm
                            if (fail_inc >= max_tries_reg || fail_inc == 3'd0)
                            begin
                                phase_next = dlc_pkg::PH_SYNC_ALARM;
                            end
                        end
                        else
                        begin
                            phase_next = dlc_pkg::PH_SYNC_OK;
                        end
                    end
                    else
                    begin
                        byte_index_next = idx_inc;
                        if (stored_pw_reg[idx] != keypad.rx_byte)
                        begin
                            mismatch_next = 1'b1;
                        end
                    end
                end
                dlc_pkg::PH_SYNC_OK:
                begin
                    if (option_reg == open_key_reg)
                    begin
                        phase_next      = dlc_pkg::PH_DOOR;
                        tick_count_next = '0;
                        motor_next      = dlc_pkg::MOTOR_STOP;
                    end
                    else
                    begin
                        phase_next      = dlc_pkg::PH_SETUP_FIRST;
                        byte_index_next = '0;
                        mismatch_next   = 1'b0;
                    end
                end
                dlc_pkg::PH_SYNC_ALARM:
                begin
                    phase_next      = dlc_pkg::PH_ALARM;
                    tick_count_next = '0;
                end
                default: ;  // bytes ignored in timed phases
            endcase
        end
        else
        begin
            case (phase_reg)
                dlc_pkg::PH_DOOR:
                begin
                    tick_count_next = tick_inc;
                    // done wins, then open, hold, close
                    if (tick_inc == done_tick_reg)
                    begin
                        motor_next      = dlc_pkg::MOTOR_STOP;
                        tick_count_next = '0;
                        phase_next      = dlc_pkg::PH_VER_OPTION;
                        fail_count_next = '0;
                        byte_index_next = '0;
                        mismatch_next   = 1'b0;
                    end
                    else if (tick_inc == open_tick_reg)
                    begin
                        motor_next = dlc_pkg::MOTOR_CW;
                    end
                    else if (tick_inc == hold_tick_reg)
                    begin
                        motor_next = dlc_pkg::MOTOR_STOP;
                    end
                    else if (tick_inc == close_tick_reg)
                    begin
                        motor_next = dlc_pkg::MOTOR_ACW;
                    end
                end
                dlc_pkg::PH_ALARM:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc == alarm_ticks_reg)
                    begin
                        tick_count_next = '0;
                        phase_next      = dlc_pkg::PH_VER_OPTION;
                        fail_count_next = '0;
                        byte_index_next = '0;
                        mismatch_next   = 1'b0;
                    end
                end
                default: ;  // ticks ignored outside timed phases
            endcase
        end
    end

    // Result fields
    always_comb
    begin
        reply_valid_next = 1'b0;
        reply_byte_next  = dlc_pkg::REPLY_FAIL;
        if (keypad.kind == dlc_pkg::KIND_BYTE && idx_last
            && (phase_reg == dlc_pkg::PH_SETUP_REPEAT || phase_reg == dlc_pkg::PH_VER_PASS))
        begin
            reply_valid_next = 1'b1;
            if (phase_next == dlc_pkg::PH_VER_OPTION || phase_next == dlc_pkg::PH_SYNC_OK)
            begin
                reply_byte_next = dlc_pkg::REPLY_PASS;
            end
        end

        buzzer_next = (phase_next == dlc_pkg::PH_ALARM);

        case (phase_next)
            dlc_pkg::PH_SETUP_FIRST,
            dlc_pkg::PH_SETUP_REPEAT: mode_next = dlc_pkg::MODE_SETUP;
            dlc_pkg::PH_DOOR:         mode_next = dlc_pkg::MODE_DOOR;
            dlc_pkg::PH_ALARM:        mode_next = dlc_pkg::MODE_ALARM;
            default:                  mode_next = dlc_pkg::MODE_VERIFY;
        endcase
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dlc_pkg::PH_SETUP_FIRST;
            byte_index_reg <= '0;
            mismatch_reg   <= 1'b0;
            fail_count_reg <= '0;
            option_reg     <= '0;
            tick_count_reg <= '0;
            motor_reg      <= dlc_pkg::MOTOR_STOP;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            mismatch_reg   <= mismatch_next;
            fail_count_reg <= fail_count_next;
            option_reg     <= option_next;
            tick_count_reg <= tick_count_next;
            motor_reg      <= motor_next;
        end
    end

    // Password stores
    always_ff @(posedge clk)
    begin
        if (accept && first_we)
        begin
            first_entry_reg[idx] <= keypad.rx_byte;
        end
        if (accept && store_copy)
        begin
            stored_pw_reg <= first_entry_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reply_valid_reg <= reply_valid_next;
            reply_byte_reg  <= reply_byte_next;
            motor_out_reg   <= motor_next;
            buzzer_reg      <= buzzer_next;
            mode_reg        <= mode_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.reply_valid = reply_valid_reg;
    assign result.reply_byte  = reply_byte_reg;
    assign result.motor_drive = motor_out_reg;
    assign result.buzzer      = buzzer_reg;
    assign result.mode        = mode_reg;

    // Checks
    a_buzzer_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.buzzer == (result.mode == dlc_pkg::MODE_ALARM)))
        else $error("buzzer level disagrees with alarm mode");

    a_reply_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.reply_valid) |->
            (result.mode == dlc_pkg::MODE_SETUP || result.mode == dlc_pkg::MODE_VERIFY))
        else $error("reply beat outside setup or verify");

    a_motor_door: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.motor_drive != dlc_pkg::MOTOR_STOP) |->
            (result.mode == dlc_pkg::MODE_DOOR))
        else $error("motor driven outside the door cycle");

    a_no_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.reply_valid) |-> (result.reply_byte == dlc_pkg::REPLY_FAIL))
        else $error("reply byte set without a reply");

endmodule
